/* hdl/tcff_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcff_pkg
// Shared types and constants for the trace control-flow fixup block.
// ----------------------------------------------------------------------------
package tcff_pkg;

    // Beat kind carried on tuser
    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_END    = 1'b1
    } tcff_op_t;

    // Configuration register indexes
    localparam int unsigned REG_FIX_TARGET = 0;
    localparam int unsigned REG_MARK_LAST  = 1;
    localparam int unsigned CFG_ADDR_W     = 3;
    localparam int unsigned CFG_DATA_W     = 32;

    // Address steps used to judge the fall-through path
    localparam logic [63:0] PC_STEP_SHORT = 64'd2;
    localparam logic [63:0] PC_STEP_LONG  = 64'd4;
    localparam logic [64:0] SIZE_GAP_MAX  = 65'd8;

    // Instruction record; first member is the top of tdata, pc sits at bit 0
    typedef struct packed {
        logic [63:0] flow_target;
        logic        flow_change;
        logic [63:0] branch_target;
        logic        target_valid;
        logic        taken;
        logic        is_branch;
        logic [3:0]  size;
        logic [63:0] pc;
    } tcff_rec_t;

    localparam int unsigned REC_W = $bits(tcff_rec_t);

    // Live configuration
    typedef struct packed {
        logic fix_target_mismatch;
        logic mark_last_on_end;
    } tcff_cfg_t;

endpackage : tcff_pkg
`default_nettype wire

/* hdl/tcff_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcff_cfg_regs
// APB register file holding the two fixup control bits.
// ----------------------------------------------------------------------------
module tcff_cfg_regs
    import tcff_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output tcff_cfg_t                  cfg
);

    logic      wr_en;
    logic      reg_idx;
    tcff_cfg_t cfg_reg;
    tcff_cfg_t cfg_next;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    // Decode a write into the addressed bit
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                1'(REG_FIX_TARGET): cfg_next.fix_target_mismatch = pwdata[0];
                1'(REG_MARK_LAST):  cfg_next.mark_last_on_end    = pwdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fix_target_mismatch <= 1'b0;
            cfg_reg.mark_last_on_end    <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed bit
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            1'(REG_FIX_TARGET): prdata[0] = cfg_reg.fix_target_mismatch;
            1'(REG_MARK_LAST):  prdata[0] = cfg_reg.mark_last_on_end;
            default:            prdata    = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule : tcff_cfg_regs
`default_nettype wire

/* hdl/tcff_repair.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcff_repair
// Repairs the held record against the next PC: size, target, flow change.
// ----------------------------------------------------------------------------
module tcff_repair
    import tcff_pkg::*;
(
    input  wire tcff_rec_t    held,
    input  wire logic  [63:0] next_pc,
    input  wire logic         fix_target_mismatch,
    output tcff_rec_t         fixed,
    output logic       [63:0] next_pc_eff
);

    logic        taken_br;
    logic        odd_fix;
    logic [64:0] pc_plus4;
    logic [63:0] pc_plus2;
    logic [64:0] gap;
    logic        gap_ok;
    logic        near;

    assign taken_br = held.is_branch && held.taken;
    assign odd_fix  = !held.is_branch && next_pc[0];

    // Fall-through candidates and the forward gap, all in parallel
    assign pc_plus4 = {1'b0, held.pc} + {1'b0, PC_STEP_LONG};
    assign pc_plus2 = held.pc + PC_STEP_SHORT;
    assign gap      = {1'b0, next_pc} - {1'b0, held.pc};

    assign next_pc_eff = odd_fix ? pc_plus4[63:0] : next_pc;

    // Odd fix lands on PC+4: a valid gap unless the add wrapped
    always_comb begin
        if (odd_fix) begin
            gap_ok = !pc_plus4[64];
            near   = 1'b1;
        end else begin
            gap_ok = !gap[64] && (gap != '0) && (gap <= SIZE_GAP_MAX);
            near   = (next_pc == pc_plus2) || (next_pc == pc_plus4[63:0]);
        end
    end

    always_comb begin
        fixed = held;
        // Size from the forward gap
        if (!taken_br && gap_ok) begin
            fixed.size = odd_fix ? PC_STEP_LONG[3:0] : gap[3:0];
        end
        // Target and flow change
        if (taken_br) begin
            if (!held.target_valid) begin
                fixed.branch_target = next_pc;
                fixed.target_valid  = 1'b1;
            end else if (fix_target_mismatch && (held.branch_target != next_pc)) begin
                fixed.branch_target = next_pc;
                fixed.flow_change   = 1'b1;
                fixed.flow_target   = next_pc;
            end
        end else if (!near) begin
            fixed.flow_change = 1'b1;
            fixed.flow_target = next_pc_eff;
        end
    end

endmodule : tcff_repair
`default_nettype wire

/* hdl/trace_control_flow_fixup_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trace_control_flow_fixup_core
// Holds one trace record back and repairs it with the PC of the next one.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries trace beats: tuser = 0 for an instruction record, 1 for end of
//   trace. m_* carries repaired records; m_tlast marks the flush caused by an
//   end beat. The APB port sets fix_target_mismatch (0x0) and
//   mark_last_on_end (0x4).
//   The first record after reset or a flush is only held. Each later record
//   pushes out the held one, repaired, on m_* in the cycle after its beat.
//   An end beat flushes the held record when mark_last_on_end is set.
//   Throughput is one beat per cycle: the repair is a single pass of
//   64-bit compares and adds between the held register and the output
//   register, and s_tready stays high while the output register is empty
//   or being drained in the same cycle.
//   When the receiver stalls with a result waiting, s_tready drops until
//   m_tready returns; nothing is lost.
//   Reset clears the held record and the output register and restores the
//   register defaults (fix 0, mark last 1).
// ----------------------------------------------------------------------------
module trace_control_flow_fixup_core
    import tcff_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input: {flow_target_in, flow_change_in, branch_target, target_valid,
    //         branch_taken, is_branch, inst_size, pc} from bit 0 = pc
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [REC_W-1:0]      s_tdata,
    // tuser: operation
    input  wire logic                  s_tuser,
    // Output: from bit 0: out_pc, out_size, out_is_branch, out_taken,
    //         out_target_valid, out_branch_target, flow_change, flow_target
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [REC_W-1:0]      m_tdata,
    // tlast: last_in_trace
    output logic                       m_tlast,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    tcff_cfg_t cfg;
    tcff_rec_t in_rec;
    tcff_rec_t fixed_rec;
    logic [63:0] next_pc_eff;
    logic      s_acc;
    logic      is_end;
    logic      emit;

    logic      held_valid_reg;
    tcff_rec_t held_reg;
    tcff_rec_t held_next;
    logic      out_valid_reg;
    tcff_rec_t out_reg;
    logic      out_last_reg;

    tcff_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_rec = tcff_rec_t'(s_tdata);
    assign is_end = (tcff_op_t'(s_tuser) == OP_END);

    tcff_repair u_repair (
        .held                (held_reg),
        .next_pc             (in_rec.pc),
        .fix_target_mismatch (cfg.fix_target_mismatch),
        .fixed               (fixed_rec),
        .next_pc_eff         (next_pc_eff)
    );

    // Accept whenever the output register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign emit     = s_acc && held_valid_reg && (!is_end || cfg.mark_last_on_end);

    // Held record: replace on a record, drop on a flushing end beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
        end else if (s_acc) begin
            if (!is_end) begin
                held_valid_reg <= 1'b1;
            end else if (cfg.mark_last_on_end) begin
                held_valid_reg <= 1'b0;
            end
        end
    end

    // New held record takes the corrected PC when one was held
    always_comb begin
        held_next    = in_rec;
        held_next.pc = held_valid_reg ? next_pc_eff : in_rec.pc;
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !is_end) begin
            held_reg <= held_next;
        end
    end

    // Output register: load on emit, clear once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg      <= is_end ? held_reg : fixed_rec;
            out_last_reg <= is_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    // A record beat always leaves something held
    a_record_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !is_end) |=> held_valid_reg)
        else $error("record beat left nothing held");

    // A flushing end beat empties the hold and shows a last result
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_end && held_valid_reg && cfg.mark_last_on_end)
            |=> (!held_valid_reg && m_tvalid && m_tlast))
        else $error("flush did not produce a last beat");

    // A record pushing out a held one yields a non-last result
    a_push_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !is_end && held_valid_reg) |=> (m_tvalid && !m_tlast))
        else $error("repaired record missing or marked last");

    // Nothing is emitted from an empty hold
    a_no_empty_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !held_valid_reg && !(m_tvalid && !m_tready)) |=> !m_tvalid)
        else $error("result emitted with nothing held");

endmodule : trace_control_flow_fixup_core
`default_nettype wire

/* sim/tcff_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcff_checker
// Watches the trace and result streams of the control-flow fixup core. It
// keeps its own copy of the held record and of the APB registers, works out
// the repaired record that each accepted beat pushes out, and compares every
// result beat field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tcff_checker
    import tcff_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [REC_W-1:0]      s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [REC_W-1:0]      m_tdata,
    input  logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    mismatch_count,
    output int                    expected_count
);

    typedef struct packed {
        tcff_rec_t rec;
        logic      last;
    } repaired_rec_t;

    // Register copy
    logic          fix_target;
    logic          mark_last;

    // Held record copy
    logic          held_valid;
    tcff_rec_t     held;

    repaired_rec_t repaired_q[$];

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // Repair the held record with the next PC and queue what leaves the block
    task automatic repair_held(input tcff_op_t op, input tcff_rec_t rec);
        logic [63:0]   next_pc;
        logic [63:0]   gap;
        logic          taken_br;
        repaired_rec_t res;
        if (op == OP_END) begin
            // flush only when enabled; otherwise keep holding
            if (held_valid && mark_last) begin
                res.rec  = held;
                res.last = 1'b1;
                repaired_q = {repaired_q, res};
                held_valid = 1'b0;
            end
        end else begin
            next_pc = rec.pc;
            if (held_valid) begin
                taken_br = held.is_branch && held.taken;
                // odd PC behind a plain instruction is bogus: assume fall-through
                if (!held.is_branch && next_pc[0])
                    next_pc = held.pc + PC_STEP_LONG;
                gap = next_pc - held.pc;
                if (!taken_br && next_pc >= held.pc && gap != 0 && {1'b0, gap} <= SIZE_GAP_MAX)
                    held.size = gap[3:0];
                if (taken_br) begin
                    if (!held.target_valid) begin
                        held.branch_target = next_pc;
                        held.target_valid  = 1'b1;
                    end else if (fix_target && held.branch_target != next_pc) begin
                        held.branch_target = next_pc;
                        held.flow_change   = 1'b1;
                        held.flow_target   = next_pc;
                    end
                end else if (next_pc != held.pc + PC_STEP_SHORT &&
                             next_pc != held.pc + PC_STEP_LONG) begin
                    held.flow_change = 1'b1;
                    held.flow_target = next_pc;
                end
                res.rec  = held;
                res.last = 1'b0;
                repaired_q = {repaired_q, res};
            end
            held       = rec;
            held.pc    = next_pc;
            held_valid = 1'b1;
        end
    endtask

    task automatic check_result(input tcff_rec_t got, input logic got_last);
        repaired_rec_t exp;
        if (repaired_q.size() == 0) begin
            $error("unexpected result beat: out_pc %h", got.pc);
            mismatch_count++;
        end else begin
            exp = repaired_q[0];
            repaired_q.delete(0);
            compare_field("out_pc", exp.rec.pc, got.pc);
            compare_field("out_size", 64'(exp.rec.size), 64'(got.size));
            compare_field("out_is_branch", 64'(exp.rec.is_branch), 64'(got.is_branch));
            compare_field("out_taken", 64'(exp.rec.taken), 64'(got.taken));
            compare_field("out_target_valid", 64'(exp.rec.target_valid),
                          64'(got.target_valid));
            compare_field("out_branch_target", exp.rec.branch_target, got.branch_target);
            compare_field("flow_change", 64'(exp.rec.flow_change), 64'(got.flow_change));
            compare_field("flow_target", exp.rec.flow_target, got.flow_target);
            compare_field("last_in_trace", 64'(exp.last), 64'(got_last));
        end
    endtask

    // Sample both streams and the APB port on the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            fix_target = 1'b0;
            mark_last  = 1'b1;
            held_valid = 1'b0;
            held       = '0;
            repaired_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (int'(paddr >> 2))
                    REG_FIX_TARGET: fix_target = pwdata[0];
                    REG_MARK_LAST:  mark_last  = pwdata[0];
                    default: ;
                endcase
            end
            // results leave before the beat taken on this edge can cause one
            if (m_tvalid && m_tready)
                check_result(tcff_rec_t'(m_tdata), m_tlast);
            if (s_tvalid && s_tready)
                repair_held(tcff_op_t'(s_tuser), tcff_rec_t'(s_tdata));
        end
        expected_count <= repaired_q.size();
    end

endmodule : tcff_checker

/* sim/tb_trace_control_flow_fixup_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trace_control_flow_fixup_core
// Drives trace beats and APB writes into the fixup core. A directed run
// covers field extremes, odd next PCs, size gaps, branch target fill and
// mismatch, address wrap and end-of-trace flushes; random phases then walk
// plausible traces under every register setting with bursty input, stalled
// output and one long output hold-off. The checker instance does the scoring.
// ----------------------------------------------------------------------------
module tb_trace_control_flow_fixup_core;
    import tcff_pkg::*;

    localparam int unsigned DRAIN_SLACK    = 4;
    // Longest correct quiet stretch is the output hold-off; allow ten times it
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_RANDOM,
        RX_RUNS
    } rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // tdata: pc, inst_size, is_branch, branch_taken, target_valid, branch_target,
    //        flow_change_in, flow_target_in (from bit 0)
    tcff_rec_t             s_tdata;
    // tuser: operation
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // tdata: out_pc, out_size, out_is_branch, out_taken, out_target_valid,
    //        out_branch_target, flow_change, flow_target (from bit 0)
    logic [REC_W-1:0]      m_tdata;
    // tlast: last_in_trace
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatch_count;
    int                    expected_count;

    // Receiver controls, written with NBAs from the stimulus process
    rx_mode_t              rx_mode     = RX_ALWAYS;
    logic                  hold_toggle = 1'b0;

    // Sender burst state and trace walk
    bit                    tx_gaps_on;
    int unsigned           burst_left;
    logic [63:0]           walk_pc;
    logic [63:0]           last_target;
    bit                    have_target;

    trace_control_flow_fixup_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tcff_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .expected_count (expected_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic tcff_rec_t trace_rec(input logic [63:0] pc, input logic [3:0] size,
                                            input logic br, input logic tk, input logic tv,
                                            input logic [63:0] bt, input logic fc,
                                            input logic [63:0] ft);
        tcff_rec_t rec;
        rec.pc            = pc;
        rec.size          = size;
        rec.is_branch     = br;
        rec.taken         = tk;
        rec.target_valid  = tv;
        rec.branch_target = bt;
        rec.flow_change   = fc;
        rec.flow_target   = ft;
        return rec;
    endfunction

    // Garbage payload for end beats
    function automatic tcff_rec_t junk_rec();
        return trace_rec(rand64(), 4'($urandom()), 1'($urandom()), 1'($urandom()),
                         1'($urandom()), rand64(), 1'($urandom()), rand64());
    endfunction

    // Next record of a plausible trace: mostly fall-through, some jumps
    task automatic make_record(output tcff_rec_t rec);
        int unsigned pick;
        logic [63:0] pc;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            pc = walk_pc + PC_STEP_LONG;
        else if (pick < 42)
            pc = walk_pc + PC_STEP_SHORT;
        else if (pick < 56)
            pc = walk_pc + 64'($urandom_range(1, 9));
        else if (pick < 68 && have_target)
            pc = last_target;
        else if (pick < 78)
            pc = walk_pc + 64'($urandom_range(0, 8191)) - 64'd4096;
        else if (pick < 88)
            pc = rand64();
        else if (pick < 94)
            pc = walk_pc - 64'($urandom_range(1, 16));
        else
            pc = 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 31));
        rec = trace_rec(pc, 4'($urandom()), $urandom_range(0, 99) < 35, 1'($urandom()),
                        1'($urandom()),
                        $urandom_range(0, 1) ? pc + 64'($urandom_range(0, 255)) : rand64(),
                        $urandom_range(0, 99) < 15, rand64());
        walk_pc     = pc;
        have_target = rec.is_branch && rec.taken && rec.target_valid;
        last_target = rec.branch_target;
    endtask

    // Offer one beat and hold it until accepted; gaps fall between bursts
    task automatic offer(input tcff_op_t op, input tcff_rec_t rec);
        int unsigned gap;
        if (tx_gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rec;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait until every outstanding result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_count != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // APB write: setup then access; upper data bits carry noise
    task automatic write_reg(input int unsigned idx, input logic value);
        logic [CFG_DATA_W-1:0] data;
        data    = $urandom();
        data[0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx << 2);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned count, input bit gaps, input rx_mode_t rx,
                             input bit with_hold);
        tcff_rec_t rec;
        tx_gaps_on = gaps;
        rx_mode   <= rx;
        for (int unsigned i = 0; i < count; i++) begin
            // long output hold-off while input keeps coming
            if (with_hold && i == count / 3)
                hold_toggle <= ~hold_toggle;
            if (with_hold && i == 2 * count / 3)
                wait_drained();
            if ($urandom_range(0, 99) < 3) begin
                offer(OP_END, junk_rec());
            end else begin
                make_record(rec);
                offer(OP_RECORD, rec);
            end
        end
    endtask

    // Output side: always ready, random, or alternating runs; hold on request
    initial begin : receiver
        int unsigned hold_left;
        int unsigned run_left;
        logic        run_ready;
        logic        hold_seen;
        hold_left = 0;
        run_left  = 0;
        run_ready = 1'b1;
        hold_seen = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        m_tready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        m_tready <= $urandom_range(0, 99) < 60;
                    end
                    default: begin
                        if (run_left == 0) begin
                            run_ready = ~run_ready;
                            run_left  = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
                        end
                        run_left--;
                        m_tready <= run_ready;
                    end
                endcase
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        s_tvalid    <= 1'b0;
        s_tuser     <= OP_RECORD;
        s_tdata     <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        aresetn     <= 1'b0;
        tx_gaps_on  = 1'b1;
        burst_left  = 0;
        walk_pc     = '0;
        last_target = '0;
        have_target = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset registers (no target fix, flush on end)
        rx_mode <= RX_RANDOM;
        offer(OP_END, junk_rec());                                   // nothing held
        offer(OP_RECORD, trace_rec(64'h0, 4'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h4, 4'd15, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h6, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        // odd next PC
        offer(OP_RECORD, trace_rec(64'h7, 4'd2, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h1000, 4'd4, 1'b1, 1'b1, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h2000, 4'd4, 1'b1, 1'b1, 1'b1, 64'h3000, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h3000, 4'd4, 1'b1, 1'b1, 1'b1, 64'h5555, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h4001, 4'd2, 1'b1, 1'b0, 1'b1, 64'h9000, 1'b0, '0));
        // gap of 8, then gap of 9, then backward
        offer(OP_RECORD, trace_rec(64'h4009, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h4012, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h4010, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b1, 64'h77));
        offer(OP_RECORD, trace_rec('1, 4'd15, 1'b1, 1'b1, 1'b1, '1, 1'b1, '1));
        offer(OP_RECORD, trace_rec('0, 4'd0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'hFFFF_FFFF_FFFF_FFFE, 4'd4, 1'b0, 1'b0, 1'b0, '0,
                                   1'b0, '0));
        // wraps to +4
        offer(OP_RECORD, trace_rec(64'h2, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_RECORD, trace_rec(64'h3, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_END, junk_rec());                                   // flush, last
        offer(OP_END, junk_rec());                                   // nothing held
        wait_drained();

        // Directed: fix target mismatches, keep held record on end
        write_reg(REG_FIX_TARGET, 1'b1);
        write_reg(REG_MARK_LAST, 1'b0);
        offer(OP_RECORD, trace_rec(64'h100, 4'd4, 1'b1, 1'b1, 1'b1, 64'h200, 1'b0, '0));
        // mismatched target
        offer(OP_RECORD, trace_rec(64'h300, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        offer(OP_END, junk_rec());                                   // flush disabled
        offer(OP_RECORD, trace_rec(64'h304, 4'd4, 1'b1, 1'b1, 1'b1, 64'h304, 1'b0, '0));
        // target matches
        offer(OP_RECORD, trace_rec(64'h304, 4'd4, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
        wait_drained();

        // Random phases across all register settings
        write_reg(REG_FIX_TARGET, 1'b0);
        write_reg(REG_MARK_LAST, 1'b1);
        run_phase(450, 1'b0, RX_ALWAYS, 1'b0);
        wait_drained();
        write_reg(REG_FIX_TARGET, 1'b1);
        write_reg(REG_MARK_LAST, 1'b1);
        run_phase(500, 1'b1, RX_RANDOM, 1'b1);
        wait_drained();
        write_reg(REG_FIX_TARGET, 1'b1);
        write_reg(REG_MARK_LAST, 1'b0);
        run_phase(500, 1'b1, RX_RUNS, 1'b0);
        wait_drained();
        write_reg(REG_FIX_TARGET, 1'b0);
        write_reg(REG_MARK_LAST, 1'b0);
        run_phase(500, 1'b1, RX_RANDOM, 1'b0);
        wait_drained();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : tb_trace_control_flow_fixup_core
